// ----- design/ftbc_pkg.sv -----
`default_nettype none

package ftbc_pkg;

  localparam int IdxW   = 12;
  localparam int CountW = 13;
  localparam int QueueDepth = 2;

  localparam logic [7:0]        AlphaMax   = 8'd255;
  localparam logic [15:0]       RoundBias  = 16'd127;
  localparam logic [15:0]       Recip255   = 16'd32897;
  localparam logic [CountW-1:0] CountReset = 13'd4096;
  localparam logic [CountW-1:0] CountMax   = 13'h1FFF;

  typedef enum logic [1:0] {
    ReqClear = 2'd0,
    ReqBlend = 2'd1,
    ReqFold  = 2'd2,
    ReqNone  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    OpNop,
    OpClear,
    OpBlend,
    OpFold
  } op_e;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [IdxW-1:0] pixel_index;
    logic [7:0]      coverage;
    logic [15:0]     color_565;
    logic            eraser;
  } req_t;

  typedef struct packed {
    logic [15:0] pixel_565;
    logic        tile_saturated;
  } res_t;

  typedef struct packed {
    op_e             op;
    logic [IdxW-1:0] addr;
    logic [7:0]      cov;
    logic [7:0]      red;
    logic [7:0]      grn;
    logic [7:0]      blu;
  } cmd_t;

endpackage

`default_nettype wire

// ----- design/ftbc_front.sv -----
`default_nettype none

module ftbc_front #(
  parameter int StoreDepth = 4096
) (
  input  ftbc_pkg::req_t req_i,
  output ftbc_pkg::cmd_t cmd_o
);

  function automatic logic [7:0] rep5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] rep6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  logic        in_range;
  logic [15:0] color;

  always_comb begin
    in_range = 32'(req_i.pixel_index) < StoreDepth;
    color    = req_i.eraser ? 16'hFFFF : req_i.color_565;

    cmd_o.addr = req_i.pixel_index;
    cmd_o.cov  = req_i.coverage;
    cmd_o.red  = rep5(color[15:11]);
    cmd_o.grn  = rep6(color[10:5]);
    cmd_o.blu  = rep5(color[4:0]);
    cmd_o.op   = ftbc_pkg::OpNop;

    if (in_range) begin
      unique case (ftbc_pkg::req_type_e'(req_i.req_type))
        ftbc_pkg::ReqClear: cmd_o.op = ftbc_pkg::OpClear;
        ftbc_pkg::ReqBlend: begin
          if (req_i.coverage != 8'd0) cmd_o.op = ftbc_pkg::OpBlend;
        end
        ftbc_pkg::ReqFold:  cmd_o.op = ftbc_pkg::OpFold;
        default:            cmd_o.op = ftbc_pkg::OpNop;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/ftbc_queue.sv -----
`default_nettype none

module ftbc_queue (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  ftbc_pkg::cmd_t data_i,
  input  wire            pop_i,
  output ftbc_pkg::cmd_t head_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int Depth = ftbc_pkg::QueueDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  ftbc_pkg::cmd_t  entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  function automatic logic [PtrW-1:0] advance(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    full_o   = count_q == CntW'(Depth);
    empty_o  = count_q == '0;
    head_o   = entry_q[rd_ptr_q];
    wr_ptr_d = push_i ? advance(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? advance(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) count_d = count_q + CntW'(1);
    if (!push_i && pop_i) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= data_i;
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |-> !full_o) else $error("push into full queue");
`endif

endmodule

`default_nettype wire

// ----- design/ftbc_back.sv -----
`default_nettype none

module ftbc_back #(
  parameter int StoreDepth = 4096
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [ftbc_pkg::CountW-1:0]   cfg_wdata_i,
  input  ftbc_pkg::cmd_t               head_i,
  input  wire                          empty_i,
  output logic                         pop_o,
  output logic                         done_o,
  output ftbc_pkg::res_t               res_o
);

  localparam int FullDepth = 1 << ftbc_pkg::IdxW;
  localparam int MemDepth  = (StoreDepth < FullDepth) ? StoreDepth : FullDepth;
  localparam int AddrW     = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam int CountW    = ftbc_pkg::CountW;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StMul1,
    StDiv1,
    StMul2,
    StDiv2,
    StWrite
  } state_e;

  function automatic logic [7:0] add_sat(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  state_e             state_q;
  logic               done_q;
  ftbc_pkg::res_t     res_q;
  logic [CountW-1:0]  sat_q, sat_d;
  logic [CountW-1:0]  pix_cnt_q;

  ftbc_pkg::cmd_t     cur_q;
  logic [31:0]        mem_q [MemDepth];
  logic [31:0]        rdata_q;
  logic [15:0]        prod1_q;
  logic [7:0]         contrib_q;
  logic [15:0]        pr_r_q, pr_g_q, pr_b_q;
  logic [7:0]         qr_r_q, qr_g_q, qr_b_q;

  logic [AddrW-1:0]   addr;
  logic [7:0]         acc, sum_r, sum_g, sum_b, rem, nacc;
  logic [15:0]        prod1;
  logic [31:0]        q1_full, qr_r_full, qr_g_full, qr_b_full;
  logic [15:0]        fold_pix;
  logic [7:0]         fold_r, fold_g, fold_b;
  logic               mem_we;
  logic [31:0]        mem_wdata;

  always_comb begin
    addr      = cur_q.addr[AddrW-1:0];
    acc       = rdata_q[31:24];
    sum_r     = rdata_q[23:16];
    sum_g     = rdata_q[15:8];
    sum_b     = rdata_q[7:0];
    prod1     = 16'(cur_q.cov) * 16'(ftbc_pkg::AlphaMax - acc) + ftbc_pkg::RoundBias;
    q1_full   = 32'(prod1_q) * 32'(ftbc_pkg::Recip255);
    qr_r_full = 32'(pr_r_q) * 32'(ftbc_pkg::Recip255);
    qr_g_full = 32'(pr_g_q) * 32'(ftbc_pkg::Recip255);
    qr_b_full = 32'(pr_b_q) * 32'(ftbc_pkg::Recip255);
    rem       = ftbc_pkg::AlphaMax - acc;
    fold_r    = add_sat(sum_r, rem);
    fold_g    = add_sat(sum_g, rem);
    fold_b    = add_sat(sum_b, rem);
    fold_pix  = {fold_r[7:3], fold_g[7:2], fold_b[7:3]};
    nacc      = add_sat(acc, contrib_q);
    pop_o     = (state_q == StIdle) && !empty_i;
    mem_we    = (state_q == StWrite) &&
                (cur_q.op == ftbc_pkg::OpClear || cur_q.op == ftbc_pkg::OpBlend);
    mem_wdata = (cur_q.op == ftbc_pkg::OpClear) ? '0 :
                {nacc, add_sat(sum_r, qr_r_q), add_sat(sum_g, qr_g_q),
                 add_sat(sum_b, qr_b_q)};

    sat_d = sat_q;
    if (state_q == StWrite) begin
      unique case (cur_q.op)
        ftbc_pkg::OpClear: begin
          if (acc == ftbc_pkg::AlphaMax && sat_q != '0) sat_d = sat_q - CountW'(1);
        end
        ftbc_pkg::OpBlend: begin
          if (nacc == ftbc_pkg::AlphaMax && acc != ftbc_pkg::AlphaMax &&
              sat_q != ftbc_pkg::CountMax) sat_d = sat_q + CountW'(1);
        end
        default: sat_d = sat_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      done_q    <= 1'b0;
      res_q     <= '0;
      sat_q     <= '0;
      pix_cnt_q <= ftbc_pkg::CountReset;
    end else begin
      done_q <= 1'b0;
      sat_q  <= sat_d;
      if (cfg_we_i) pix_cnt_q <= cfg_wdata_i;
      unique case (state_q)
        StIdle: begin
          if (!empty_i) begin
            if (head_i.op == ftbc_pkg::OpNop) begin
              done_q               <= 1'b1;
              res_q.pixel_565      <= '0;
              res_q.tile_saturated <= sat_q == pix_cnt_q;
            end else begin
              state_q <= StRead;
            end
          end
        end
        StRead:  state_q <= (cur_q.op == ftbc_pkg::OpBlend) ? StMul1 : StWrite;
        StMul1:  state_q <= StDiv1;
        StDiv1:  state_q <= StMul2;
        StMul2: begin
          if (contrib_q == '0) begin
            done_q               <= 1'b1;
            res_q.pixel_565      <= '0;
            res_q.tile_saturated <= sat_q == pix_cnt_q;
            state_q              <= StIdle;
          end else begin
            state_q <= StDiv2;
          end
        end
        StDiv2:  state_q <= StWrite;
        StWrite: begin
          done_q               <= 1'b1;
          res_q.pixel_565      <= (cur_q.op == ftbc_pkg::OpFold) ? fold_pix : '0;
          res_q.tile_saturated <= sat_d == pix_cnt_q;
          state_q              <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= head_i;
    if (state_q == StMul1) prod1_q <= prod1;
    if (state_q == StDiv1) contrib_q <= q1_full[30:23];
    if (state_q == StMul2) begin
      pr_r_q <= 16'(cur_q.red) * 16'(contrib_q);
      pr_g_q <= 16'(cur_q.grn) * 16'(contrib_q);
      pr_b_q <= 16'(cur_q.blu) * 16'(contrib_q);
    end
    if (state_q == StDiv2) begin
      qr_r_q <= qr_r_full[30:23];
      qr_g_q <= qr_g_full[30:23];
      qr_b_q <= qr_b_full[30:23];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[addr] <= mem_wdata;
    if (state_q == StRead) rdata_q <= mem_q[addr];
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  a_sat_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sat_q != $past(sat_q)) |->
      (sat_q == $past(sat_q) + 13'd1 || sat_q == $past(sat_q) - 13'd1))
    else $error("saturated count moved by more than one");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == StIdle) else $error("result word outside idle");
`endif

endmodule

`default_nettype wire

// ----- design/front_to_back_tile_compositor_core.sv -----
`default_nettype none

// Front-to-back tile compositor, RGB565 in and out.
// Command channel: req_i is taken at a rising edge with start_i high and busy_o
// low. A front stage classifies the word (clear, composite, fold, or no-op for
// an out-of-window index, zero coverage or unused type) and expands the color,
// then a two-entry queue feeds the back end that owns the tile store.
// Result channel: done_o is high for one cycle with res_o; the receiver cannot
// hold it off. Every accepted word yields exactly one result, in order.
// A composite whose contribution rounds to 0 ends without writing the store.
// The back-end sequencer takes the next word from the queue only once it is idle
// again; it does one read-modify-write of the single-port store per word and
// runs the contribution and per-channel divides through two multiply stages.
// cfg_we_i/cfg_wdata_i write the active pixel count; the user must do so only
// while idle, which the block itself does not enforce.
// Reset clears the saturated count, sets the pixel count to 4096 and empties
// the queue; store contents are undefined until a pixel is cleared.

module front_to_back_tile_compositor_core #(
  parameter int TILE_WIDTH  = 64,
  parameter int TILE_HEIGHT = 64
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start_i,
  output logic                       busy_o,
  input  ftbc_pkg::req_t             req_i,
  output logic                       done_o,
  output ftbc_pkg::res_t             res_o,
  input  wire                        cfg_we_i,
  input  wire [ftbc_pkg::CountW-1:0] cfg_wdata_i
);

  localparam int StoreDepth = TILE_WIDTH * TILE_HEIGHT;

  ftbc_pkg::cmd_t cmd, head;
  logic           full, empty, pop;

  ftbc_front #(
    .StoreDepth (StoreDepth)
  ) u_front (
    .req_i (req_i),
    .cmd_o (cmd)
  );

  ftbc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (start_i && !full),
    .data_i  (cmd),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  ftbc_back #(
    .StoreDepth (StoreDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .done_o      (done_o),
    .res_o       (res_o)
  );

  assign busy_o = full;

endmodule

`default_nettype wire
